### sv/iba_pkg.sv
// Shared constants for the inode and block allocator.
// Field widths, request and status codes, bitmap row geometry.
// No dependencies.
`default_nettype none

package iba_pkg;

    localparam int INODE_COUNT = 32;
    localparam int BLOCK_COUNT = 512;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int BLKO_W   = 9;

    // block bitmap is held as rows of MAP_W bits
    localparam int MAP_W  = 32;
    localparam int MAP_AW = 5;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CREATE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd3;

endpackage

`default_nettype wire

### sv/iba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module iba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/inode_and_block_allocator.sv
// Inode and block allocator top level: FSM over an inode RAM and a block bitmap RAM.
// Depends on iba_pkg and iba_ram.
//
// Usage:
//   Requests enter on start/i_func/i_file_id, taken when start is high and busy low.
//   Each request gives one result, shown for one cycle with o_done high on
//   o_status/o_slot/o_block. The receiver cannot stall; results are not held.
//   Only one request is in flight; busy stays high until its result is out.
//   Results: lookup and delete report not found on a miss; create reports
//   exists if the id is present, else no space if no inode or no bitmap
//   block is free, else takes the first free inode and the lowest free block.
//   The inode scan reads the inode RAM one entry a cycle; the free-block
//   search reads the bitmap RAM one 32-bit row a cycle. That is the limit.
//   Reset: inode busy flags clear at once; then a clearing pass writes the
//   bitmap (blocks 0 and 1 used, rest free) with busy held high.
`default_nettype none

module inode_and_block_allocator #(
    parameter int INODE_COUNT = iba_pkg::INODE_COUNT,
    parameter int BLOCK_COUNT = iba_pkg::BLOCK_COUNT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [iba_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [iba_pkg::ID_W-1:0]      i_file_id,
    output logic                               o_done,
    output logic      [iba_pkg::STATUS_W-1:0]  o_status,
    output logic      [iba_pkg::SLOT_W-1:0]    o_slot,
    output logic      [iba_pkg::BLKO_W-1:0]    o_block
);

    localparam int IW    = (INODE_COUNT > 1) ? $clog2(INODE_COUNT) : 1;
    localparam int BW    = $clog2(BLOCK_COUNT);
    localparam int ROWS  = (BLOCK_COUNT + iba_pkg::MAP_W - 1) / iba_pkg::MAP_W;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MW    = iba_pkg::MAP_W;
    localparam int MA    = iba_pkg::MAP_AW;
    localparam int IDW   = iba_pkg::ID_W;
    localparam int IRW   = IDW + BW;

    localparam logic [IW-1:0] LAST_IDX = IW'(INODE_COUNT - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_BSCAN = 3'd3;
    localparam logic [2:0] S_BWR   = 3'd4;

    logic [2:0]                      r_state, n_state;
    logic [IW-1:0]                   r_idx, n_idx;
    logic [RW-1:0]                   r_row, n_row;
    logic [iba_pkg::FUNC_W-1:0]      r_func, n_func;
    logic [IDW-1:0]                  r_id, n_id;
    logic [INODE_COUNT-1:0]          r_ibusy, n_ibusy;
    logic                            r_free_vld, n_free_vld;
    logic [IW-1:0]                   r_free_idx, n_free_idx;
    logic [IW-1:0]                   r_slot, n_slot;
    logic [BW-1:0]                   r_blk, n_blk;
    logic                            r_done, n_done;
    logic [iba_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [IW-1:0]                   r_oslot, n_oslot;
    logic [BW-1:0]                   r_oblk, n_oblk;

    logic            w_ino_we;
    logic [IW-1:0]   w_ino_waddr;
    logic [IRW-1:0]  w_ino_wdata;
    logic [IW-1:0]   w_ino_raddr;
    logic [IRW-1:0]  w_ino_rdata;
    logic            w_map_we;
    logic [RW-1:0]   w_map_waddr;
    logic [MW-1:0]   w_map_wdata;
    logic [RW-1:0]   w_map_raddr;
    logic [MW-1:0]   w_map_rdata;

    logic [IDW-1:0]        w_rd_file;
    logic [BW-1:0]         w_rd_blk;
    logic                  w_hit;
    logic                  w_free_now;
    logic                  w_free_vld;
    logic [IW-1:0]         w_free_idx;
    logic [MW-1:0]         w_clr_row;
    logic                  w_zfound;
    logic [MA-1:0]         w_zpos;
    logic [RW+MA-1:0]      w_new_full;
    logic [BW-1:0]         w_new_blk;
    logic [BW+RW+MA-1:0]   w_rd_ext;
    logic [BW+RW+MA-1:0]   w_r_ext;
    logic [MA-1:0]         w_del_pos;
    logic [IW+iba_pkg::SLOT_W-1:0] w_oslot_ext;
    logic [BW+iba_pkg::BLKO_W-1:0] w_oblk_ext;

    iba_ram #(
        .WIDTH (IRW),
        .DEPTH (INODE_COUNT),
        .AW    (IW)
    ) u_inode_ram (
        .i_clk   (i_clk),
        .i_we    (w_ino_we),
        .i_waddr (w_ino_waddr),
        .i_wdata (w_ino_wdata),
        .i_raddr (w_ino_raddr),
        .o_rdata (w_ino_rdata)
    );

    iba_ram #(
        .WIDTH (MW),
        .DEPTH (ROWS),
        .AW    (RW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    assign w_rd_file  = w_ino_rdata[IRW-1:BW];
    assign w_rd_blk   = w_ino_rdata[BW-1:0];
    assign w_hit      = r_ibusy[r_idx] && (w_rd_file == r_id);
    assign w_free_now = !r_ibusy[r_idx];
    assign w_free_vld = r_free_vld || w_free_now;
    assign w_free_idx = r_free_vld ? r_free_idx : r_idx;

    assign w_rd_ext  = {{(RW+MA){1'b0}}, w_rd_blk};
    assign w_r_ext   = {{(RW+MA){1'b0}}, r_blk};
    assign w_del_pos = w_r_ext[MA-1:0];

    assign w_new_full = {r_row, w_zpos};
    assign w_new_blk  = w_new_full[BW-1:0];

    // reset image of one bitmap row: blocks 0, 1 and any beyond the end are used
    always_comb begin
        logic [RW+MA:0] cidx;
        cidx = '0;
        for (int k = 0; k < MW; k++) begin
            cidx = {1'b0, r_row, MA'(k)};
            w_clr_row[k] = (cidx < (RW+MA+1)'(2)) || (cidx >= (RW+MA+1)'(BLOCK_COUNT));
        end
    end

    // lowest clear bit of the row being examined
    always_comb begin
        w_zfound = 1'b0;
        w_zpos   = '0;
        for (int k = MW - 1; k >= 0; k--) begin
            if (!w_map_rdata[k]) begin
                w_zfound = 1'b1;
                w_zpos   = MA'(k);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_row      = r_row;
        n_func     = r_func;
        n_id       = r_id;
        n_ibusy    = r_ibusy;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_slot     = r_slot;
        n_blk      = r_blk;
        n_done     = 1'b0;
        n_status   = r_status;
        n_oslot    = r_oslot;
        n_oblk     = r_oblk;

        w_ino_we    = 1'b0;
        w_ino_waddr = r_slot;
        w_ino_wdata = {r_id, w_new_blk};
        w_ino_raddr = '0;
        w_map_we    = 1'b0;
        w_map_waddr = r_row;
        w_map_wdata = w_clr_row;
        w_map_raddr = '0;

        unique case (r_state)
            S_CLR: begin
                w_map_we = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func     = i_func;
                    n_id       = i_file_id;
                    n_idx      = '0;
                    n_free_vld = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                w_ino_raddr = r_idx + IW'(1);
                if (w_free_now && !r_free_vld) begin
                    n_free_vld = 1'b1;
                    n_free_idx = r_idx;
                end
                if (w_hit || r_idx == LAST_IDX) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_oslot  = '0;
                    n_oblk   = '0;
                    if (r_func == iba_pkg::FN_CREATE) begin
                        if (w_hit) begin
                            n_status = iba_pkg::ST_EXISTS;
                        end else if (!w_free_vld) begin
                            n_status = iba_pkg::ST_NO_SPACE;
                        end else begin
                            n_done  = 1'b0;
                            n_slot  = w_free_idx;
                            n_row   = '0;
                            n_state = S_BSCAN;
                        end
                    end else if (!w_hit) begin
                        n_status = iba_pkg::ST_NOT_FOUND;
                    end else if (r_func == iba_pkg::FN_DELETE) begin
                        n_done         = 1'b0;
                        n_ibusy[r_idx] = 1'b0;
                        n_slot         = r_idx;
                        n_blk          = w_rd_blk;
                        w_map_raddr    = w_rd_ext[RW+MA-1:MA];
                        n_state        = S_BWR;
                    end else begin
                        n_status = iba_pkg::ST_OK;
                        n_oslot  = r_idx;
                        n_oblk   = w_rd_blk;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_BSCAN: begin
                w_map_raddr = r_row + RW'(1);
                if (w_zfound) begin
                    w_map_we       = 1'b1;
                    w_map_waddr    = r_row;
                    w_map_wdata    = w_map_rdata | (MW'(1) << w_zpos);
                    w_ino_we       = 1'b1;
                    n_ibusy[r_slot] = 1'b1;
                    n_done         = 1'b1;
                    n_status       = iba_pkg::ST_OK;
                    n_oslot        = r_slot;
                    n_oblk         = w_new_blk;
                    n_state        = S_IDLE;
                end else if (r_row == LAST_ROW) begin
                    n_done   = 1'b1;
                    n_status = iba_pkg::ST_NO_SPACE;
                    n_oslot  = '0;
                    n_oblk   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            S_BWR: begin
                w_map_we    = 1'b1;
                w_map_waddr = w_r_ext[RW+MA-1:MA];
                w_map_wdata = w_map_rdata & ~(MW'(1) << w_del_pos);
                n_done      = 1'b1;
                n_status    = iba_pkg::ST_OK;
                n_oslot     = r_slot;
                n_oblk      = r_blk;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_row      <= '0;
            r_ibusy    <= '0;
            r_free_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_ibusy    <= n_ibusy;
            r_free_vld <= n_free_vld;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_func     <= n_func;
        r_id       <= n_id;
        r_free_idx <= n_free_idx;
        r_slot     <= n_slot;
        r_blk      <= n_blk;
        r_status   <= n_status;
        r_oslot    <= n_oslot;
        r_oblk     <= n_oblk;
    end

    assign w_oslot_ext = {{iba_pkg::SLOT_W{1'b0}}, r_oslot};
    assign w_oblk_ext  = {{iba_pkg::BLKO_W{1'b0}}, r_oblk};

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_slot   = w_oslot_ext[iba_pkg::SLOT_W-1:0];
    assign o_block  = w_oblk_ext[iba_pkg::BLKO_W-1:0];

endmodule

`default_nettype wire

### sim/iba_checker.sv
// Checker for the inode and block allocator: watches the request and result
// channels, keeps its own copy of the inode table and block map, and compares results.
// Depends on iba_pkg.
`timescale 1ns / 1ps

module iba_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire logic [iba_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [iba_pkg::ID_W-1:0]      i_file_id,
    input  wire logic                          i_done,
    input  wire logic [iba_pkg::STATUS_W-1:0]  i_status,
    input  wire logic [iba_pkg::SLOT_W-1:0]    i_slot,
    input  wire logic [iba_pkg::BLKO_W-1:0]    i_block,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_ok_count,
    output int                                 o_exists_count,
    output int                                 o_missing_count,
    output int                                 o_full_count
);

    typedef struct packed {
        logic [iba_pkg::STATUS_W-1:0] status;
        logic [iba_pkg::SLOT_W-1:0]   slot;
        logic [iba_pkg::BLKO_W-1:0]   block;
    } t_fs_reply;

    logic                       inode_used [iba_pkg::INODE_COUNT];
    logic [iba_pkg::ID_W-1:0]   inode_id   [iba_pkg::INODE_COUNT];
    logic [iba_pkg::BLKO_W-1:0] inode_blk  [iba_pkg::INODE_COUNT];
    logic                       block_used [iba_pkg::BLOCK_COUNT];

    t_fs_reply due_replies [$];

    function automatic void format_tables();
        for (int i = 0; i < iba_pkg::INODE_COUNT; i++) begin
            inode_used[i] = 1'b0;
            inode_id[i]   = '0;
            inode_blk[i]  = '0;
        end
        for (int b = 0; b < iba_pkg::BLOCK_COUNT; b++)
            block_used[b] = (b < 2);
    endfunction

    // applies one request to the table copy and returns its reply
    function automatic t_fs_reply run_fs_request(logic [iba_pkg::FUNC_W-1:0] fn,
                                                 logic [iba_pkg::ID_W-1:0] id);
        int        hit;
        int        spare_slot;
        int        free_block;
        t_fs_reply r;
        hit        = -1;
        spare_slot = -1;
        free_block = -1;
        for (int i = iba_pkg::INODE_COUNT - 1; i >= 0; i--) begin
            if (inode_used[i] && inode_id[i] == id)
                hit = i;
            if (!inode_used[i])
                spare_slot = i;
        end
        for (int b = iba_pkg::BLOCK_COUNT - 1; b >= 0; b--)
            if (!block_used[b])
                free_block = b;
        r.status = iba_pkg::ST_NOT_FOUND;
        r.slot   = '0;
        r.block  = '0;
        if (fn == iba_pkg::FN_CREATE) begin
            if (hit >= 0) begin
                r.status = iba_pkg::ST_EXISTS;
            end else if (spare_slot < 0 || free_block < 0) begin
                r.status = iba_pkg::ST_NO_SPACE;
            end else begin
                inode_used[spare_slot] = 1'b1;
                inode_id[spare_slot]   = id;
                inode_blk[spare_slot]  = free_block[iba_pkg::BLKO_W-1:0];
                block_used[free_block] = 1'b1;
                r.status = iba_pkg::ST_OK;
                r.slot   = spare_slot[iba_pkg::SLOT_W-1:0];
                r.block  = free_block[iba_pkg::BLKO_W-1:0];
            end
        end else if (hit >= 0) begin
            // lookup, delete and the spare code all report the match
            r.status = iba_pkg::ST_OK;
            r.slot   = hit[iba_pkg::SLOT_W-1:0];
            r.block  = inode_blk[hit];
            if (fn == iba_pkg::FN_DELETE) begin
                inode_used[hit]            = 1'b0;
                block_used[inode_blk[hit]] = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fs_reply want;
        if (!i_rst_n) begin
            format_tables();
            due_replies.delete();
        end else begin
            if (i_done) begin
                if (due_replies.size() == 0) begin
                    $display("%0t: unexpected result status %0d slot %0d block %0d",
                             $time, i_status, i_slot, i_block);
                    o_fail_count++;
                end else begin
                    want = due_replies.pop_front();
                    o_checked++;
                    case (i_status)
                        iba_pkg::ST_OK:        o_ok_count++;
                        iba_pkg::ST_EXISTS:    o_exists_count++;
                        iba_pkg::ST_NOT_FOUND: o_missing_count++;
                        iba_pkg::ST_NO_SPACE:  o_full_count++;
                        default:               ;
                    endcase
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_slot !== want.slot) begin
                        $display("%0t: slot expected %0d got %0d", $time, want.slot, i_slot);
                        o_fail_count++;
                    end
                    if (i_block !== want.block) begin
                        $display("%0t: block expected %0d got %0d",
                                 $time, want.block, i_block);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                due_replies.push_back(run_fs_request(i_func, i_file_id));
        end
        o_pending = due_replies.size();
    end

endmodule

### sim/tb_inode_and_block_allocator.sv
// Testbench top for the inode and block allocator: clock, reset, request
// stimulus with random gaps, and the verdict. Depends on iba_pkg, iba_checker
// and the allocator RTL.
`timescale 1ns / 1ps

module tb_inode_and_block_allocator;

    localparam int IDW = iba_pkg::ID_W;
    localparam logic [iba_pkg::FUNC_W-1:0] FN_SPARE = 2'd3;
    localparam int RANDOM_REQUESTS = 1300;
    localparam int POOL_SIZE       = 44;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 64;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [iba_pkg::FUNC_W-1:0]   i_func;
    logic [IDW-1:0]               i_file_id;
    logic                         o_done;
    logic [iba_pkg::STATUS_W-1:0] o_status;
    logic [iba_pkg::SLOT_W-1:0]   o_slot;
    logic [iba_pkg::BLKO_W-1:0]   o_block;

    int fail_count;
    int pending;
    int checked;
    int ok_count;
    int exists_count;
    int missing_count;
    int full_count;
    int cycle_count;
    int issued;

    logic [IDW-1:0] id_pool [POOL_SIZE];

    inode_and_block_allocator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_func    (i_func),
        .i_file_id (i_file_id),
        .o_done    (o_done),
        .o_status  (o_status),
        .o_slot    (o_slot),
        .o_block   (o_block)
    );

    iba_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (i_func),
        .i_file_id       (i_file_id),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_slot          (o_slot),
        .i_block         (o_block),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_ok_count      (ok_count),
        .o_exists_count  (exists_count),
        .o_missing_count (missing_count),
        .o_full_count    (full_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_inode_and_block_allocator failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(logic [iba_pkg::FUNC_W-1:0] fn, logic [IDW-1:0] id);
        i_func    <= fn;
        i_file_id <= id;
        start     <= 1'b1;
        while (busy)
            @(negedge i_clk);
        @(negedge i_clk);
        issued++;
    endtask

    task automatic idle_between(bit no_idle);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!no_idle) begin
            if (r >= 90)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic pick_request(int create_pct, output logic [iba_pkg::FUNC_W-1:0] fn,
                                output logic [IDW-1:0] id);
        int r;
        r = $urandom_range(0, 99);
        if (r < create_pct) begin
            fn = iba_pkg::FN_CREATE;
        end else begin
            r = $urandom_range(0, 19);
            if (r == 0)
                fn = FN_SPARE;
            else if (r < 11)
                fn = iba_pkg::FN_DELETE;
            else
                fn = iba_pkg::FN_LOOKUP;
        end
        if ($urandom_range(0, 99) < 85)
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            id = IDW'($urandom_range(0, 16'hFFFF));
    endtask

    initial begin
        logic [iba_pkg::FUNC_W-1:0] fn;
        logic [IDW-1:0]             id;
        int                         create_pct;
        int                         phase_len;
        int                         sent;
        bit                         no_idle;
        issued    = 0;
        sent      = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_func    = iba_pkg::FN_LOOKUP;
        i_file_id = '0;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = IDW'($urandom_range(0, 16'hFFFF));
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, extreme ids, duplicate create, spare code, slot and block reuse
        send_request(iba_pkg::FN_LOOKUP, 16'h0000);
        send_request(iba_pkg::FN_DELETE, 16'hFFFF);
        send_request(iba_pkg::FN_CREATE, 16'h0000);
        send_request(iba_pkg::FN_CREATE, 16'hFFFF);
        send_request(iba_pkg::FN_CREATE, 16'h0000);
        send_request(iba_pkg::FN_LOOKUP, 16'hFFFF);
        send_request(FN_SPARE,           16'hFFFF);
        send_request(iba_pkg::FN_LOOKUP, 16'h0000);
        send_request(iba_pkg::FN_DELETE, 16'h0000);
        send_request(iba_pkg::FN_LOOKUP, 16'h0000);
        send_request(iba_pkg::FN_CREATE, 16'h5A5A);
        send_request(iba_pkg::FN_CREATE, 16'hA5A5);
        send_request(iba_pkg::FN_DELETE, 16'hFFFF);
        send_request(FN_SPARE,           16'h1234);
        send_request(iba_pkg::FN_DELETE, 16'hA5A5);
        send_request(iba_pkg::FN_DELETE, 16'h5A5A);

        // each phase draws a random create share, so phases fill or drain the inode table
        while (sent < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 2))
                0:       create_pct = 20;
                1:       create_pct = 45;
                default: create_pct = 75;
            endcase
            phase_len = $urandom_range(30, 120);
            no_idle   = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
                pick_request(create_pct, fn, id);
                send_request(fn, id);
                sent++;
                idle_between(no_idle);
            end
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests issued, %0d results checked over fill and drain phases",
                 issued, checked);
        $display("ok %0d, already exists %0d, not found %0d, no space %0d",
                 ok_count, exists_count, missing_count, full_count);
        if (fail_count == 0)
            $display("tb_inode_and_block_allocator passed");
        else
            $display("tb_inode_and_block_allocator failed");
        $finish;
    end

endmodule
